### hdl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and constants of the token bucket shaper: event kinds,
// result codes, controller states and the result record.
// ----------------------------------------------------------------------------
package tbs_pkg;

	localparam int WAIT_QUEUE_DEPTH  = 16;
	localparam int SERVE_QUEUE_DEPTH = 16;

	localparam int NEED_W  = 8;   // tokens_needed / token_level width
	localparam int ID_W    = 16;  // packet sequence number width
	localparam int LEVEL_W = 5;   // queue level fields in a result

	localparam logic [NEED_W-1:0] DEPTH_AT_RESET = 8'd10;

	// input event kind
	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_ARRIVE = 2'd1,
		FUNC_SERVE  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// result code
	typedef enum logic [2:0] {
		EVT_TOKEN_ADDED   = 3'd0,
		EVT_TOKEN_DROPPED = 3'd1,
		EVT_TOO_BIG       = 3'd2,
		EVT_QUEUED        = 3'd3,
		EVT_QUEUE_FULL    = 3'd4,
		EVT_MOVED         = 3'd5,
		EVT_SERVICE       = 3'd6,
		EVT_NOTHING       = 3'd7
	} evt_t;

	// controller state
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_MOVE
	} state_t;

	// one result item
	typedef struct packed {
		evt_t               code;
		logic [ID_W-1:0]    id;
		logic [NEED_W-1:0]  level;
		logic [LEVEL_W-1:0] wq_lvl;
		logic [LEVEL_W-1:0] sq_lvl;
		logic               last;
	} result_t;

endpackage

### hdl/tbs_queue.sv
// ----------------------------------------------------------------------------
// tbs_queue
// Circular queue in a synchronous memory. The head entry is read into a
// register every cycle, so head_data shows the head in the cycle after the
// head pointer or the head entry last changed.
// ----------------------------------------------------------------------------
module tbs_queue
	import tbs_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic [CW-1:0]    count,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [CW-1:0]    count_q;
	logic [WIDTH-1:0] rd_q;

	// pointer wrap for any depth
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// memory write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_data;
		end
		rd_q <= mem[head_q];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= ptr_inc(tail_q);
			end
			if (pop) begin
				head_q <= ptr_inc(head_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_data = rd_q;
	assign count     = count_q;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

endmodule

### hdl/tbs_out_reg.sv
// ----------------------------------------------------------------------------
// tbs_out_reg
// Output holding register: keeps one result until the master side takes
// it, and takes the next one in the same cycle the current one leaves.
// ----------------------------------------------------------------------------
module tbs_out_reg
	import tbs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_data,
	output logic    free,
	output logic    m_tvalid,
	input  logic    m_tready,
	output logic [39:0] m_tdata,  // packet_id, token_level, first_queue_level,
	                              // second_queue_level, zero fill
	output logic [2:0]  m_tuser,  // event_code
	output logic        m_tlast   // last
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || m_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= load_data;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'd0, res_q.sq_lvl, res_q.wq_lvl, res_q.level, res_q.id};
	assign m_tuser  = res_q.code;
	assign m_tlast  = res_q.last;

endmodule

### hdl/token_bucket_shaper_unit.sv
// Flow: an accepted item passes the READ and EXEC states; its first result
//   is loaded from EXEC, a move result from MOVE, each once the output is free.
// Items: a new item is taken only in IDLE, after the last one is done; READ
//   waits out the registered head read of the queue memories.
// Reset: bucket empty, sequence number zero, both queues empty, depth 10;
//   queue memories are not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
// token_bucket_shaper_unit
// Event driven token bucket shaper: token ticks fill the bucket, arrivals
// join a wait queue, the wait queue head moves to a serve queue once the
// bucket holds its need and the serve queue has room, serve requests pop the serve queue.
// ----------------------------------------------------------------------------
module token_bucket_shaper_unit
	import tbs_pkg::*;
#(
	parameter int WAIT_DEPTH  = WAIT_QUEUE_DEPTH,
	parameter int SERVE_DEPTH = SERVE_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: bucket_depth
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,    // bucket_depth
	// events in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // tokens_needed
	input  logic [1:0]  s_tuser,     // func
	// results out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,     // packet_id, token_level, first_queue_level,
	                                 // second_queue_level, zero fill
	output logic [2:0]  m_tuser,     // event_code
	output logic        m_tlast      // last
);

	localparam int WCW    = $clog2(WAIT_DEPTH + 1);
	localparam int SCW    = $clog2(SERVE_DEPTH + 1);
	localparam int WENT_W = ID_W + NEED_W;

	state_t state_q, state_nxt;

	logic [NEED_W-1:0] depth_q;
	logic [NEED_W-1:0] tokens_q;
	logic [ID_W-1:0]   seq_q;
	func_t             func_q;
	logic [NEED_W-1:0] need_q;
	logic [NEED_W-1:0] mv_need_q;
	logic [ID_W-1:0]   mv_id_q;

	// queue ports
	logic              wq_push, wq_pop, wq_full, wq_empty;
	logic [WENT_W-1:0] wq_head, wq_wdata;
	logic [WCW-1:0]    wq_count;
	logic              sq_push, sq_pop, sq_full, sq_empty;
	logic [ID_W-1:0]   sq_head, sq_wdata;
	logic [SCW-1:0]    sq_count;

	// output register
	logic    out_free, out_load;
	result_t out_data;

	// first-result evaluation
	result_t           ex_res;
	logic              ex_push, ex_pop, ex_move;
	logic [NEED_W-1:0] ex_tokens;
	logic [ID_W-1:0]   ex_id_new;
	logic [NEED_W-1:0] ex_hd_need;
	logic [ID_W-1:0]   ex_hd_id;
	logic [WCW-1:0]    ex_wcnt;
	logic [SCW-1:0]    ex_scnt;
	logic              exec_fire, move_fire;

	tbs_queue #(.DEPTH(WAIT_DEPTH), .WIDTH(WENT_W)) u_wait_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (wq_push),
		.push_data (wq_wdata),
		.pop       (wq_pop),
		.head_data (wq_head),
		.count     (wq_count),
		.full      (wq_full),
		.empty     (wq_empty)
	);

	tbs_queue #(.DEPTH(SERVE_DEPTH), .WIDTH(ID_W)) u_serve_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (sq_push),
		.push_data (sq_wdata),
		.pop       (sq_pop),
		.head_data (sq_head),
		.count     (sq_count),
		.full      (sq_full),
		.empty     (sq_empty)
	);

	tbs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.load_data (out_data),
		.free      (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	assign cfg_ready = 1'b1;

	// evaluate the event: first result, queue updates, whether a move follows
	always_comb begin
		ex_push   = 1'b0;
		ex_pop    = 1'b0;
		ex_tokens = tokens_q;
		ex_id_new = seq_q + 1'b1;
		ex_res    = '0;
		unique case (func_q)
			FUNC_TICK: begin
				if (tokens_q < depth_q) begin
					ex_tokens   = tokens_q + 1'b1;
					ex_res.code = EVT_TOKEN_ADDED;
				end else begin
					ex_res.code = EVT_TOKEN_DROPPED;
				end
			end
			FUNC_ARRIVE: begin
				ex_res.id = ex_id_new;
				if (need_q > depth_q) begin
					ex_res.code = EVT_TOO_BIG;
				end else if (wq_full) begin
					ex_res.code = EVT_QUEUE_FULL;
				end else begin
					ex_res.code = EVT_QUEUED;
					ex_push     = 1'b1;
				end
			end
			FUNC_SERVE: begin
				if (!sq_empty) begin
					ex_res.code = EVT_SERVICE;
					ex_res.id   = sq_head;
					ex_pop      = 1'b1;
				end else begin
					ex_res.code = EVT_NOTHING;
				end
			end
			default: begin
				ex_res.code = EVT_NOTHING;
			end
		endcase
		ex_wcnt = wq_count + WCW'(ex_push);
		ex_scnt = sq_count - SCW'(ex_pop);
		// an empty wait queue gets the new packet as its head
		if (wq_empty) begin
			ex_hd_need = need_q;
			ex_hd_id   = ex_id_new;
		end else begin
			ex_hd_need = wq_head[NEED_W-1:0];
			ex_hd_id   = wq_head[WENT_W-1:NEED_W];
		end
		ex_move = (func_q == FUNC_TICK || func_q == FUNC_ARRIVE) && (ex_wcnt != '0)
			&& !sq_full && (ex_hd_need <= ex_tokens);
		ex_res.level  = ex_tokens;
		ex_res.wq_lvl = LEVEL_W'(ex_wcnt);
		ex_res.sq_lvl = LEVEL_W'(ex_scnt);
		ex_res.last   = !ex_move;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (func_q == FUNC_NONE) begin
					state_nxt = ST_IDLE;
				end else if (out_free) begin
					state_nxt = ex_move ? ST_MOVE : ST_IDLE;
				end
			end
			ST_MOVE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		exec_fire = 1'b0;
		move_fire = 1'b0;
		out_load  = 1'b0;
		out_data  = ex_res;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_READ: begin
			end
			ST_EXEC: begin
				exec_fire = out_free && (func_q != FUNC_NONE);
				out_load  = exec_fire;
			end
			ST_MOVE: begin
				move_fire       = out_free;
				out_load        = move_fire;
				out_data.code   = EVT_MOVED;
				out_data.id     = mv_id_q;
				out_data.level  = tokens_q - mv_need_q;
				out_data.wq_lvl = LEVEL_W'(wq_count - 1'b1);
				out_data.sq_lvl = LEVEL_W'(sq_count + 1'b1);
				out_data.last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// queue controls
	assign wq_push  = exec_fire && ex_push;
	assign wq_wdata = {ex_id_new, need_q};
	assign wq_pop   = move_fire;
	assign sq_push  = move_fire;
	assign sq_wdata = mv_id_q;
	assign sq_pop   = exec_fire && ex_pop;

	// control and bucket state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			depth_q  <= DEPTH_AT_RESET;
			tokens_q <= '0;
			seq_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				depth_q <= cfg_data;
			end
			if (exec_fire) begin
				tokens_q <= ex_tokens;
				if (func_q == FUNC_ARRIVE) begin
					seq_q <= ex_id_new;
				end
			end else if (move_fire) begin
				tokens_q <= tokens_q - mv_need_q;
			end
		end
	end

	// item and pending-move payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= func_t'(s_tuser);
			need_q <= s_tdata;
		end
		if (exec_fire) begin
			mv_need_q <= ex_hd_need;
			mv_id_q   <= ex_hd_id;
		end
	end

	// a move never takes more tokens than the bucket holds
	a_move_tokens: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE) |-> (mv_need_q <= tokens_q))
		else $error("move needs more tokens than held");

	// a move result only follows a first result that was not marked last
	a_move_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE && $past(state_q) != ST_MOVE)
			|-> ($past(state_q) == ST_EXEC && $past(exec_fire) && !$past(ex_res.last)))
		else $error("move state entered without pending move");

	// queue memories are never pushed full or popped empty
	a_wait_push: assert property (@(posedge clk) disable iff (!arst_n)
		wq_push |-> !wq_full)
		else $error("wait queue overflow");

	a_serve_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_pop || wq_pop) |-> (!sq_empty || !sq_pop) && (!wq_empty || !wq_pop))
		else $error("queue underflow");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for token_bucket_shaper_unit. Events go in on the
// slave stream and results come out on the master stream. An in-bench
// model of the bucket and of both packet queues predicts every result. A
// short directed table runs first. Random phases follow at several bucket
// depths, then a calm tail with no idling.
// ----------------------------------------------------------------------------
module tb;
	import tbs_pkg::*;

	localparam int RUN_LIMIT   = 2000000;  // cycles before the watchdog fires
	localparam int PAUSE_CYC   = 8;        // settle time after the last result
	localparam int PHASE_ITEMS = 250;
	localparam int CALM_ITEMS  = 200;
	localparam int HOLD_AT     = 400;      // result count that starts the long hold
	localparam int HOLD_CYC    = 300;
	localparam int MAX_PRINTS  = 200;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // tokens_needed
	logic [1:0]  s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // packet_id, token_level, first/second queue level, zero fill
	logic [2:0]  m_tuser;   // event_code
	logic        m_tlast;

	token_bucket_shaper_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// shaper model: bucket, sequence counter, wait line and serve line
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [NEED_W-1:0] need;
	} waiting_pkt_t;

	logic [NEED_W-1:0] depth_m;
	logic [NEED_W-1:0] tokens_m;
	logic [ID_W-1:0]   seq_m;
	waiting_pkt_t      wait_line[$];
	logic [ID_W-1:0]   serve_line[$];
	result_t           event_results[$];   // results of the event just modeled
	result_t           pending_results[$]; // results still owed by the block

	int error_count;
	int result_count;
	int cycle_count;
	bit calm;        // no idling on either side
	bit quiet;       // sender runs without gaps for a while

	function automatic void log_result(evt_t code, logic [ID_W-1:0] id);
		result_t r;
		r.code   = code;
		r.id     = id;
		r.level  = tokens_m;
		r.wq_lvl = LEVEL_W'(wait_line.size());
		r.sq_lvl = LEVEL_W'(serve_line.size());
		r.last   = 1'b0;
		event_results.push_back(r);
	endfunction

	// at most one head packet moves per event
	function automatic void move_head();
		waiting_pkt_t p;
		if (wait_line.size() == 0 || serve_line.size() >= SERVE_QUEUE_DEPTH)
			return;
		p = wait_line[0];
		if (p.need > tokens_m)
			return;
		tokens_m = tokens_m - p.need;
		void'(wait_line.pop_front());
		serve_line.push_back(p.id);
		log_result(EVT_MOVED, p.id);
	endfunction

	function automatic void shape_event(func_t f, logic [NEED_W-1:0] need);
		waiting_pkt_t p;
		result_t      r;
		logic [ID_W-1:0] id;
		event_results.delete();
		case (f)
			FUNC_TICK: begin
				if (tokens_m < depth_m) begin
					tokens_m = tokens_m + 1'b1;
					log_result(EVT_TOKEN_ADDED, '0);
				end else begin
					log_result(EVT_TOKEN_DROPPED, '0);
				end
				move_head();
			end
			FUNC_ARRIVE: begin
				seq_m = seq_m + 1'b1;
				if (need > depth_m) begin
					log_result(EVT_TOO_BIG, seq_m);
				end else if (wait_line.size() >= WAIT_QUEUE_DEPTH) begin
					log_result(EVT_QUEUE_FULL, seq_m);
				end else begin
					p.id   = seq_m;
					p.need = need;
					wait_line.push_back(p);
					log_result(EVT_QUEUED, seq_m);
				end
				move_head();
			end
			FUNC_SERVE: begin
				if (serve_line.size() > 0) begin
					id = serve_line.pop_front();
					log_result(EVT_SERVICE, id);
				end else begin
					log_result(EVT_NOTHING, '0);
				end
			end
			default: ;  // unused kind: no result
		endcase
		if (event_results.size() > 0) begin
			r = event_results.pop_back();
			r.last = 1'b1;
			event_results.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// directed table; typed rows carry their single result
	// ------------------------------------------------------------------
	typedef struct {
		func_t             f;
		logic [NEED_W-1:0] need;
		int                reps;
		bit                typed;
		result_t           want;
	} plan_row_t;

	localparam int PLAN_ROWS = 17;

	plan_row_t plan [PLAN_ROWS] = '{
		// serve on empty, then the unused kind
		'{FUNC_SERVE,  8'd0,   1,  1'b1, '{EVT_NOTHING,     16'd0,  8'd0,  5'd0,  5'd0, 1'b1}},
		'{FUNC_NONE,   8'd0,   1,  1'b0, '0},
		'{FUNC_TICK,   8'd0,   1,  1'b1, '{EVT_TOKEN_ADDED, 16'd0,  8'd1,  5'd0,  5'd0, 1'b1}},
		// largest need is too big at depth 10
		'{FUNC_ARRIVE, 8'd255, 1,  1'b1, '{EVT_TOO_BIG,     16'd1,  8'd1,  5'd0,  5'd0, 1'b1}},
		// zero need moves at once
		'{FUNC_ARRIVE, 8'd0,   1,  1'b0, '0},
		'{FUNC_ARRIVE, 8'd10,  1,  1'b1, '{EVT_QUEUED,      16'd3,  8'd1,  5'd1,  5'd1, 1'b1}},
		'{FUNC_TICK,   8'd0,   9,  1'b0, '0},
		'{FUNC_SERVE,  8'd0,   1,  1'b1, '{EVT_SERVICE,     16'd2,  8'd0,  5'd0,  5'd1, 1'b1}},
		'{FUNC_SERVE,  8'd0,   1,  1'b0, '0},
		'{FUNC_SERVE,  8'd0,   1,  1'b1, '{EVT_NOTHING,     16'd0,  8'd0,  5'd0,  5'd0, 1'b1}},
		// fill the bucket, then overflow it
		'{FUNC_TICK,   8'd0,   12, 1'b0, '0},
		'{FUNC_ARRIVE, 8'd11,  1,  1'b1, '{EVT_TOO_BIG,     16'd4,  8'd10, 5'd0,  5'd0, 1'b1}},
		'{FUNC_ARRIVE, 8'd10,  1,  1'b0, '0},
		// empty bucket: the wait line fills and then refuses
		'{FUNC_ARRIVE, 8'd7,   17, 1'b0, '0},
		'{FUNC_ARRIVE, 8'd0,   1,  1'b1, '{EVT_QUEUE_FULL,  16'd23, 8'd0,  5'd16, 5'd1, 1'b1}},
		'{FUNC_TICK,   8'd0,   7,  1'b0, '0},
		'{FUNC_SERVE,  8'd0,   20, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// mismatch reporting and result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		if (error_count < MAX_PRINTS)
			$display("ERROR result %0d: %s got %0h want %0h", result_count, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending, code", int'(m_tuser), 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.code)
					report_mismatch("event_code", int'(m_tuser), int'(want.code));
				if (m_tdata[15:0] != want.id)
					report_mismatch("packet_id", int'(m_tdata[15:0]), int'(want.id));
				if (m_tdata[23:16] != want.level)
					report_mismatch("token_level", int'(m_tdata[23:16]), int'(want.level));
				if (m_tdata[28:24] != want.wq_lvl)
					report_mismatch("first_queue_level", int'(m_tdata[28:24]),
						int'(want.wq_lvl));
				if (m_tdata[33:29] != want.sq_lvl)
					report_mismatch("second_queue_level", int'(m_tdata[33:29]),
						int'(want.sq_lvl));
				if (m_tlast != want.last)
					report_mismatch("last", int'(m_tlast), int'(want.last));
			end
			result_count++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// result receiver: random stalls, one long hold to back up the block
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		bit held;
		stall_left = 0;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && result_count >= HOLD_AT) begin
				held = 1'b1;
				stall_left = HOLD_CYC;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// event sender; entered and left at a falling edge
	// ------------------------------------------------------------------
	task automatic offer_event(func_t f, logic [NEED_W-1:0] need, bit typed, result_t want);
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= need;
		do @(posedge clk); while (!s_tready);
		shape_event(f, need);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (event_results[i]) pending_results.push_back(event_results[i]);
		@(negedge clk);
	endtask

	task automatic send_event(func_t f, logic [NEED_W-1:0] need);
		offer_event(f, need, 1'b0, '0);
	endtask

	// wait for the block to go idle, then write the bucket depth
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (PAUSE_CYC) @(negedge clk);
	endtask

	task automatic set_depth(logic [NEED_W-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		depth_m = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one random event; counted is low for the ignored kind
	task automatic random_event(int tick_pct, int arrive_pct, output bit counted);
		int pick;
		int r;
		logic [NEED_W-1:0] need;
		func_t f;
		pick = $urandom_range(0, 99);
		r = $urandom_range(0, 99);
		if (r < 40)
			need = NEED_W'($urandom_range(0, depth_m));
		else if (r < 80)
			need = NEED_W'($urandom_range(0, (depth_m < 4) ? depth_m : 4));
		else
			need = NEED_W'($urandom_range(0, 255));
		if (pick < tick_pct)
			f = FUNC_TICK;
		else if (pick < tick_pct + arrive_pct)
			f = FUNC_ARRIVE;
		else if (pick < 98)
			f = FUNC_SERVE;
		else
			f = FUNC_NONE;
		send_event(f, need);
		counted = (f != FUNC_NONE);
	endtask

	task automatic random_phase(int items, int tick_pct, int arrive_pct);
		int n;
		bit counted;
		n = 0;
		while (n < items) begin
			random_event(tick_pct, arrive_pct, counted);
			if (counted)
				n++;
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int tick_pct;
		error_count   = 0;
		result_count  = 0;
		cycle_count   = 0;
		calm          = 1'b0;
		quiet         = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		depth_m       = DEPTH_AT_RESET;
		tokens_m      = '0;
		seq_m         = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (plan[i])
			for (int k = 0; k < plan[i].reps; k++)
				offer_event(plan[i].f, plan[i].need, plan[i].typed, plan[i].want);

		// random phases at deepest, shallowest and in-between depths
		set_depth(8'd255);
		random_phase(PHASE_ITEMS, 60, 30);
		set_depth(8'd1);
		random_phase(PHASE_ITEMS, 40, 30);
		set_depth(NEED_W'($urandom_range(2, 254)));
		tick_pct = $urandom_range(20, 60);
		random_phase(PHASE_ITEMS, tick_pct, $urandom_range(20, 90 - tick_pct));
		set_depth(8'd255);
		random_phase(PHASE_ITEMS, 30, 50);
		set_depth(NEED_W'($urandom_range(1, 254)));
		random_phase(PHASE_ITEMS, 45, 35);

		// calm tail
		calm = 1'b1;
		set_depth(NEED_W'($urandom_range(1, 255)));
		random_phase(CALM_ITEMS, 40, 35);

		drain_results();
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
